// File: hdl/xcd_pkg.sv
// Shared constants, codes and types of the XOR checksum packet deframer.
// No dependencies; the front, queue, back and top level refer to this package by scoped names.
`default_nettype none

package xcd_pkg;

  // Largest payload that a frame may announce.
  localparam int MAX_PAYLOAD = 32;

  localparam int IDX_W   = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int CNT_W   = $clog2(MAX_PAYLOAD + 1);
  localparam int ADDR_W  = IDX_W + 1;
  localparam int MEM_DEPTH = 2 ** ADDR_W;
  localparam logic [7:0] LEN_MAX = 8'(MAX_PAYLOAD);

  // Job queue between the front and the back.
  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  // Result status codes.
  localparam logic [1:0] ST_GOOD = 2'd0;
  localparam logic [1:0] ST_LEN  = 2'd1;
  localparam logic [1:0] ST_CSUM = 2'd2;

  // Trailer characters.
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  // One finished frame, as handed from the front to the back.
  typedef struct packed {
    logic [1:0] status;
    logic [7:0] sender;
    logic [7:0] receiver;
    logic [7:0] kind;
    logic [7:0] length;
    logic       bank;
    logic       has_data;
  } xcd_job_t;

  // Payload buffer write port driven by the front.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } xcd_wr_t;

  // Back reports that a buffer bank has been fully drained.
  typedef struct packed {
    logic valid;
    logic bank;
  } xcd_done_t;

endpackage

`default_nettype wire

// File: hdl/xcd_in_if.sv
// Receive byte channel of the packet deframer: valid/ready handshake with one byte.
// No dependencies.
`default_nettype none

interface xcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// File: hdl/xcd_out_if.sv
// Result channel of the packet deframer: valid/ready handshake with one result.
// No dependencies.
`default_nettype none

interface xcd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] sender_id;
  logic [7:0] receiver_id;
  logic [7:0] message_kind;
  logic [7:0] payload_length;
  logic [7:0] data_byte;
  logic       data_valid;
  logic       last;

  modport source (output valid, output status, output sender_id, output receiver_id,
                  output message_kind, output payload_length, output data_byte,
                  output data_valid, output last, input ready);
  modport sink   (input valid, input status, input sender_id, input receiver_id,
                  input message_kind, input payload_length, input data_byte,
                  input data_valid, input last, output ready);
endinterface

`default_nettype wire

// File: hdl/xcd_front.sv
// Front of the deframer: frame parser, checksum and payload buffer writes.
// Depends on xcd_pkg and xcd_in_if.
`default_nettype none

module xcd_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  xcd_in_if.sink                  in_ch,
  input  wire logic               cfg_wr_en,
  input  wire logic [7:0]         cfg_wr_data,
  input  wire logic               q_full,
  output xcd_pkg::xcd_job_t       q_job,
  output logic                    q_push,
  output xcd_pkg::xcd_wr_t        mem_wr,
  input  wire xcd_pkg::xcd_done_t done
);

  localparam logic [3:0] PH_HUNT     = 4'd0;
  localparam logic [3:0] PH_SENDER   = 4'd1;
  localparam logic [3:0] PH_RECEIVER = 4'd2;
  localparam logic [3:0] PH_KIND     = 4'd3;
  localparam logic [3:0] PH_LENGTH   = 4'd4;
  localparam logic [3:0] PH_PAYLOAD  = 4'd5;
  localparam logic [3:0] PH_CHECK    = 4'd6;
  localparam logic [3:0] PH_TRAIL    = 4'd7;
  localparam logic [3:0] PH_AFTER_CR = 4'd8;

  logic [3:0]                 phase_r, phase_nxt;
  logic [7:0]                 header_r;
  logic [7:0]                 sender_r, sender_nxt;
  logic [7:0]                 receiver_r, receiver_nxt;
  logic [7:0]                 kind_r, kind_nxt;
  logic [7:0]                 length_r, length_nxt;
  logic [xcd_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [xcd_pkg::CNT_W-1:0]  count_inc;
  logic [7:0]                 xor_r, xor_nxt;
  logic                       wbank_r, wbank_nxt;
  logic [1:0]                 busy_r, busy_nxt;
  logic                       accept;
  logic [7:0]                 b;
  logic                       sum_ok;

  assign b         = in_ch.rx_byte;
  assign accept    = in_ch.valid && in_ch.ready;
  assign count_inc = count_r + xcd_pkg::CNT_W'(1);
  assign sum_ok    = (b == xor_r);

  // Stall where a job may be queued and the queue is full, or where the bank
  // being filled is still being drained.
  always_comb begin
    in_ch.ready = 1'b1;
    if ((phase_r == PH_LENGTH || phase_r == PH_CHECK) && q_full) begin
      in_ch.ready = 1'b0;
    end
    if (phase_r == PH_PAYLOAD && busy_r[wbank_r]) begin
      in_ch.ready = 1'b0;
    end
  end

  always_comb begin
    phase_nxt    = phase_r;
    sender_nxt   = sender_r;
    receiver_nxt = receiver_r;
    kind_nxt     = kind_r;
    length_nxt   = length_r;
    count_nxt    = count_r;
    xor_nxt      = xor_r;
    wbank_nxt    = wbank_r;
    busy_nxt     = busy_r;
    q_push       = 1'b0;
    q_job.status   = xcd_pkg::ST_GOOD;
    q_job.sender   = sender_r;
    q_job.receiver = receiver_r;
    q_job.kind     = kind_r;
    q_job.length   = length_r;
    q_job.bank     = wbank_r;
    q_job.has_data = 1'b0;
    mem_wr.en    = 1'b0;
    mem_wr.addr  = {wbank_r, count_r[xcd_pkg::IDX_W-1:0]};
    mem_wr.data  = b;

    if (done.valid) begin
      busy_nxt[done.bank] = 1'b0;
    end

    if (accept) begin
      unique case (phase_r)
        PH_SENDER: begin
          sender_nxt = b;
          phase_nxt  = PH_RECEIVER;
        end
        PH_RECEIVER: begin
          receiver_nxt = b;
          phase_nxt    = PH_KIND;
        end
        PH_KIND: begin
          kind_nxt  = b;
          phase_nxt = PH_LENGTH;
        end
        PH_LENGTH: begin
          length_nxt = b;
          if (b > xcd_pkg::LEN_MAX) begin
            q_push       = 1'b1;
            q_job.status = xcd_pkg::ST_LEN;
            q_job.length = b;
            phase_nxt    = PH_HUNT;
          end else begin
            xor_nxt   = sender_r ^ receiver_r ^ kind_r ^ b;
            count_nxt = '0;
            phase_nxt = (b == 8'd0) ? PH_CHECK : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          mem_wr.en = 1'b1;
          xor_nxt   = xor_r ^ b;
          count_nxt = count_inc;
          if (8'(count_inc) >= length_r) begin
            phase_nxt = PH_CHECK;
          end
        end
        PH_CHECK: begin
          q_push         = 1'b1;
          q_job.status   = sum_ok ? xcd_pkg::ST_GOOD : xcd_pkg::ST_CSUM;
          q_job.has_data = sum_ok && (length_r != 8'd0);
          if (sum_ok && (length_r != 8'd0)) begin
            busy_nxt[wbank_r] = 1'b1;
            wbank_nxt         = !wbank_r;
          end
          phase_nxt = PH_TRAIL;
        end
        PH_TRAIL: begin
          if (b == xcd_pkg::CH_CR) begin
            phase_nxt = PH_AFTER_CR;
          end else if (b == xcd_pkg::CH_LF) begin
            phase_nxt = PH_HUNT;
          end else begin
            phase_nxt = (b == header_r) ? PH_SENDER : PH_HUNT;
          end
        end
        PH_AFTER_CR: begin
          if (b == xcd_pkg::CH_LF) begin
            phase_nxt = PH_HUNT;
          end else begin
            phase_nxt = (b == header_r) ? PH_SENDER : PH_HUNT;
          end
        end
        default: begin
          phase_nxt = (b == header_r) ? PH_SENDER : PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HUNT;
      header_r   <= 8'd0;
      sender_r   <= 8'd0;
      receiver_r <= 8'd0;
      kind_r     <= 8'd0;
      length_r   <= 8'd0;
      count_r    <= '0;
      xor_r      <= 8'd0;
      wbank_r    <= 1'b0;
      busy_r     <= 2'b00;
    end else begin
      phase_r    <= phase_nxt;
      sender_r   <= sender_nxt;
      receiver_r <= receiver_nxt;
      kind_r     <= kind_nxt;
      length_r   <= length_nxt;
      count_r    <= count_nxt;
      xor_r      <= xor_nxt;
      wbank_r    <= wbank_nxt;
      busy_r     <= busy_nxt;
      if (cfg_wr_en) begin
        header_r <= cfg_wr_data;
      end
    end
  end

`ifndef SYNTHESIS
  // A payload byte must never land in a bank that still awaits draining.
  a_wr_free_bank: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr.en |-> !busy_r[wbank_r])
    else $error("payload write into a busy bank");
`endif

endmodule

`default_nettype wire

// File: hdl/xcd_queue.sv
// Short job queue between the deframer's front and back, held in flip-flops.
// Depends on xcd_pkg.
`default_nettype none

module xcd_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire xcd_pkg::xcd_job_t push_job,
  output logic                   full,
  input  wire logic              pop,
  output xcd_pkg::xcd_job_t      head,
  output logic                   not_empty
);

  xcd_pkg::xcd_job_t            slot_r [xcd_pkg::Q_DEPTH];
  logic [xcd_pkg::QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [xcd_pkg::QCNT_W-1:0]   count_r;

  assign full      = (count_r == xcd_pkg::QCNT_W'(xcd_pkg::Q_DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + xcd_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + xcd_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + xcd_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - xcd_pkg::QCNT_W'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("job queue underflow");
`endif

endmodule

`default_nettype wire

// File: hdl/xcd_back.sv
// Back of the deframer: two-bank payload buffer and the result sequencer.
// Depends on xcd_pkg and xcd_out_if.
`default_nettype none

module xcd_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire xcd_pkg::xcd_wr_t  mem_wr,
  input  wire xcd_pkg::xcd_job_t q_head,
  input  wire logic              q_not_empty,
  output logic                   q_pop,
  output xcd_pkg::xcd_done_t     done,
  xcd_out_if.source              out_ch
);

  localparam logic [1:0] B_IDLE   = 2'd0;
  localparam logic [1:0] B_FETCH  = 2'd1;
  localparam logic [1:0] B_LOAD   = 2'd2;
  localparam logic [1:0] B_SINGLE = 2'd3;

  logic [7:0] mem [xcd_pkg::MEM_DEPTH];
  logic [7:0] rd_data_r;
  logic       rd_en;

  logic [1:0]                state_r, state_nxt;
  xcd_pkg::xcd_job_t         job_r, job_nxt;
  logic [xcd_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic                      is_last;
  logic                      out_free;
  logic                      load;
  logic                      load_data;

  logic       out_valid_r;
  logic [1:0] st_r;
  logic [7:0] snd_r, rcv_r, knd_r, len_r, dat_r;
  logic       dv_r, last_r;

  assign out_free = !out_valid_r || out_ch.ready;
  assign is_last  = ((8'(idx_r) + 8'd1) == job_r.length);

  always_comb begin
    state_nxt  = state_r;
    job_nxt    = job_r;
    idx_nxt    = idx_r;
    q_pop      = 1'b0;
    rd_en      = 1'b0;
    load       = 1'b0;
    load_data  = 1'b0;
    done.valid = 1'b0;
    done.bank  = job_r.bank;
    unique case (state_r)
      B_IDLE: begin
        if (q_not_empty) begin
          q_pop     = 1'b1;
          job_nxt   = q_head;
          idx_nxt   = '0;
          state_nxt = q_head.has_data ? B_FETCH : B_SINGLE;
        end
      end
      B_FETCH: begin
        rd_en     = 1'b1;
        state_nxt = B_LOAD;
      end
      B_LOAD: begin
        if (out_free) begin
          load      = 1'b1;
          load_data = 1'b1;
          if (is_last) begin
            done.valid = 1'b1;
            state_nxt  = B_IDLE;
          end else begin
            idx_nxt   = idx_r + xcd_pkg::IDX_W'(1);
            state_nxt = B_FETCH;
          end
        end
      end
      B_SINGLE: begin
        if (out_free) begin
          load      = 1'b1;
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_wr.en) begin
      mem[mem_wr.addr] <= mem_wr.data;
    end
    if (rd_en) begin
      rd_data_r <= mem[{job_r.bank, idx_r}];
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    idx_r <= idx_nxt;
    if (load) begin
      st_r   <= job_r.status;
      snd_r  <= job_r.sender;
      rcv_r  <= job_r.receiver;
      knd_r  <= job_r.kind;
      len_r  <= job_r.length;
      dat_r  <= load_data ? rd_data_r : 8'd0;
      dv_r   <= load_data;
      last_r <= load_data ? is_last : 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = st_r;
  assign out_ch.sender_id      = snd_r;
  assign out_ch.receiver_id    = rcv_r;
  assign out_ch.message_kind   = knd_r;
  assign out_ch.payload_length = len_r;
  assign out_ch.data_byte      = dat_r;
  assign out_ch.data_valid     = dv_r;
  assign out_ch.last           = last_r;

`ifndef SYNTHESIS
  // A bank is released in the same cycle as its final data result is loaded.
  a_done_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    done.valid |=> (out_valid_r && last_r && dv_r))
    else $error("bank released without a final data result");
`endif

endmodule

`default_nettype wire

// File: hdl/xor_checksum_packet_deframer.sv
// Top level of the XOR checksum length-prefixed packet deframer.
// Depends on xcd_pkg, xcd_in_if, xcd_out_if, xcd_front, xcd_queue and xcd_back.
//
//   Channel   Direction  Handshake        Contents
//   in_chan   in         valid/ready      rx_byte: one received serial byte
//   out_chan  out        valid/ready      status, header fields, data_byte, data_valid, last
//   cfg_*     in         write enable     cfg_wr_data: start-of-packet header value
//
// The front takes one byte per cycle; it stalls on a payload byte while the bank it is filling
// still awaits draining, and on a length or checksum byte while the job queue is full.
// The back reads each payload byte from the registered buffer (B_FETCH), then loads it as a result
// (B_LOAD) once the output register is free, and fetches no new byte until the last one is loaded.
// Error and empty-packet results are loaded from B_SINGLE after leaving the queue, with no buffer read.
// Reset is synchronous and active low; there is no clearing pass over the buffer.
`default_nettype none

module xor_checksum_packet_deframer (
  input  wire logic       clk,
  input  wire logic       rst_n,
  xcd_in_if.sink          in_chan,
  xcd_out_if.source       out_chan,
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data
);

  // Finished frames travel to the back as jobs through a short queue.
  xcd_pkg::xcd_job_t  push_job;
  xcd_pkg::xcd_job_t  head_job;
  logic               q_push;
  logic               q_pop;
  logic               q_full;
  logic               q_not_empty;

  // The front writes payload bytes into the back's two-bank buffer; the back
  // hands a bank back once its run of results has been loaded.
  xcd_pkg::xcd_wr_t   mem_wr;
  xcd_pkg::xcd_done_t done;

  xcd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_chan),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_full      (q_full),
    .q_job       (push_job),
    .q_push      (q_push),
    .mem_wr      (mem_wr),
    .done        (done)
  );

  xcd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (q_pop),
    .head      (head_job),
    .not_empty (q_not_empty)
  );

  xcd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .mem_wr      (mem_wr),
    .q_head      (head_job),
    .q_not_empty (q_not_empty),
    .q_pop       (q_pop),
    .done        (done),
    .out_ch      (out_chan)
  );

endmodule

`default_nettype wire
